// ===== design/tgm_pkg.sv =====
`timescale 1ns / 1ps
package tgm_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [1:0] CfgZone   = 2'd0;
  localparam logic [1:0] CfgTravel = 2'd1;
  localparam logic [1:0] CfgBtnR   = 2'd2;
  localparam logic [1:0] CfgStartR = 2'd3;

  localparam logic [1:0] KindDown   = 2'd0;
  localparam logic [1:0] KindMotion = 2'd1;
  localparam logic [1:0] KindUp     = 2'd2;
  localparam logic [1:0] KindNone   = 2'd3;

  localparam logic [16:0] AxisFull = 17'd32767;
  localparam int unsigned NumCircles = 5;

  function automatic logic [15:0] circle_cx(input logic [2:0] k);
    unique case (k)
      3'd0: circle_cx = 16'd60948;
      3'd1: circle_cx = 16'd52429;
      3'd2: circle_cx = 16'd52429;
      3'd3: circle_cx = 16'd60948;
      default: circle_cx = 16'd57016;
    endcase
  endfunction

  function automatic logic [15:0] circle_cy(input logic [2:0] k);
    unique case (k)
      3'd0: circle_cy = 16'd45875;
      3'd1: circle_cy = 16'd51118;
      3'd2: circle_cy = 16'd19661;
      3'd3: circle_cy = 16'd14418;
      default: circle_cy = 16'd61604;
    endcase
  endfunction

  typedef struct packed {
    logic        start;
    logic [33:0] num;
    logic [17:0] den;
  } div_req_t;
endpackage

// ===== design/tgm_divider.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module tgm_divider
  import tgm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        busy_o,
  output logic [33:0] quot_o
);
  logic [33:0] q_q, q_d;
  logic [17:0] rem_q, rem_d;
  logic [17:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [18:0] trial;

  assign trial = {rem_q, q_q[33]} - {1'b0, den_q};

  always_comb begin
    q_d = q_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    if (req_i.start) begin
      q_d = req_i.num;
      rem_d = '0;
      den_d = req_i.den;
      cnt_d = 6'd34;
    end else if (cnt_q != 6'd0) begin
      if (!trial[18]) begin
        rem_d = trial[17:0];
        q_d = {q_q[32:0], 1'b1};
      end else begin
        rem_d = {rem_q[16:0], q_q[33]};
        q_d = {q_q[32:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != 6'd0) || req_i.start;
  assign quot_o = q_q;
endmodule

// ===== design/touch_to_gamepad_mapper_top.sv =====
`timescale 1ns / 1ps
// Touch to gamepad mapper. Takes finger down/motion/up items and emits one gamepad
// state item per handled event (none for a down with no free slot, a motion with an
// unknown finger, or kind 3). After the accepting edge the slot search walks the
// slots; the scan then squares the two radii and the travel on the one shared
// 17x17 squarer, then passes each free or stick slot and squares dx and dy for each
// of the NumCircles circles per button finger. A held stick adds a bit-by-bit root
// and two divisions on the divider before the output register is loaded.
// s_axis_tready is low while an event is processed; the result sits in an output
// register and the next item is accepted while it waits.
module touch_to_gamepad_mapper_top
  import tgm_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // low to high: finger_id[15:0], touch_x[31:16], touch_y[47:32]
  input  logic [47:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // low to high: button_mask[4:0], stick_active[5], stick_x[21:6], stick_y[37:22],
  // origin_x[53:38], origin_y[69:54], current_x[85:70], current_y[101:86], zero pad
  output logic [103:0] m_axis_tdata
);
  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SW:0] LastSlot = (SW + 1)'(NUM_SLOTS - 1);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StFind  = 9'b000000010,
    StScan  = 9'b000000100,
    StRoot  = 9'b000001000,
    StDivX  = 9'b000010000,
    StWaitX = 9'b000100000,
    StDivY  = 9'b001000000,
    StWaitY = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] zone_q, travel_q, btnr_q, startr_q;
  logic [NUM_SLOTS-1:0] act_q, own_q;
  logic [15:0] fid_q [NUM_SLOTS];
  logic [31:0] org_q [NUM_SLOTS];
  logic [31:0] pos_q [NUM_SLOTS];
  logic held_q;

  logic [1:0]  kind_q;
  logic [15:0] id_q, x_q, y_q;
  logic [SW:0] idx_q;
  logic [2:0]  circ_q;
  logic [4:0]  mask_q;
  logic        stick_q;
  logic [31:0] sorg_q, scur_q;
  logic [35:0] acc_q;
  logic        sq_ph_q;
  logic [33:0] rv_q, rres_q, rbit_q;
  logic [17:0] div_q;
  logic [15:0] ax_q;
  logic        divgo_q;
  logic [31:0] r2b_q, r2s_q, t2_q;

  logic        ov_q;
  logic [103:0] od_q;

  logic [SW-1:0] idx;
  assign idx = idx_q[SW-1:0];

  // shared squarer
  logic [16:0] sq_a;
  logic [33:0] sq_p;
  assign sq_p = sq_a * sq_a;

  logic [15:0] px, py, ccx, ccy, rr;
  logic [31:0] r2;
  assign px  = pos_q[idx][15:0];
  assign py  = pos_q[idx][31:16];
  assign ccx = circle_cx(circ_q);
  assign ccy = circle_cy(circ_q);
  assign rr  = (circ_q == 3'd4 || circ_q == 3'd6) ? startr_q : btnr_q;
  assign r2  = (circ_q == 3'd4) ? r2s_q : r2b_q;

  logic [16:0] ddx, ddy, sdx, sdy;
  assign ddx = (px >= ccx) ? {1'b0, px - ccx} : {1'b0, ccx - px};
  assign ddy = (py >= ccy) ? {1'b0, py - ccy} : {1'b0, ccy - py};
  logic signed [16:0] sdxs, sdys;
  assign sdxs = $signed({1'b0, scur_q[15:0]}) - $signed({1'b0, sorg_q[15:0]});
  assign sdys = $signed({1'b0, scur_q[31:16]}) - $signed({1'b0, sorg_q[31:16]});
  assign sdx = sdxs[16] ? 17'(-sdxs) : sdxs;
  assign sdy = sdys[16] ? 17'(-sdys) : sdys;

  logic [1:0] sq_sel;
  always_comb begin
    unique case (sq_sel)
      2'd0: sq_a = sq_ph_q ? ddy : ddx;
      2'd1: sq_a = {1'b0, rr};
      2'd2: sq_a = sq_ph_q ? sdy : sdx;
      default: sq_a = {1'b0, travel_q};
    endcase
  end

  div_req_t dreq;
  logic dbusy;
  logic [33:0] dquot;
  tgm_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .busy_o(dbusy), .quot_o(dquot));

  logic [16:0] absd;
  assign absd = (state_q == StDivX) ? sdx : sdy;
  always_comb begin
    dreq.start = divgo_q;
    dreq.num = 34'(absd) * 34'(AxisFull);
    dreq.den = div_q;
  end

  logic [15:0] axis_q_w;
  logic neg;
  assign neg = (state_q == StWaitX) ? sdxs[16] : sdys[16];
  assign axis_q_w = neg ? 16'(-dquot[15:0]) : dquot[15:0];

  logic take;
  assign s_axis_tready = (state_q == StIdle);
  assign take = s_axis_tvalid && s_axis_tready;

  logic [35:0] rtrial;
  assign rtrial = {2'b0, rres_q} + {2'b0, rbit_q};

  logic slot_hit;
  assign slot_hit = act_q[idx] && fid_q[idx] == id_q;

  always_comb begin
    state_d = state_q;
    sq_sel = 2'd0;
    unique case (state_q)
      StIdle: if (take) state_d = StFind;
      StFind: begin
        if (kind_q == KindDown ? !act_q[idx] : slot_hit) state_d = StScan;
        else if (idx_q == LastSlot) state_d = (kind_q == KindUp) ? StScan : StIdle;
      end
      StScan: sq_sel = 2'd0;
      StRoot: sq_sel = 2'd2;
      StDivX, StWaitX, StDivY, StWaitY, StOut: sq_sel = 2'd2;
      default: state_d = StIdle;
    endcase
    if (state_q == StScan) begin
      if (circ_q == 3'd7) sq_sel = 2'd3;
      else if (circ_q >= 3'd5) sq_sel = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      zone_q <= 16'd29491;
      travel_q <= 16'd8520;
      btnr_q <= 16'd4915;
      startr_q <= 16'd3604;
      act_q <= '0;
      own_q <= '0;
      held_q <= 1'b0;
      ov_q <= 1'b0;
      divgo_q <= 1'b0;
    end else begin
      divgo_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgZone:   zone_q <= cfg_data_i;
          CfgTravel: travel_q <= cfg_data_i;
          CfgBtnR:   btnr_q <= cfg_data_i;
          default:   startr_q <= cfg_data_i;
        endcase
      end
      if (ov_q && m_axis_tready) ov_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (take) begin
            kind_q <= s_axis_tuser;
            id_q <= s_axis_tdata[15:0];
            x_q <= s_axis_tdata[31:16];
            y_q <= s_axis_tdata[47:32];
            idx_q <= '0;
            state_q <= (s_axis_tuser == KindNone) ? StIdle : StFind;
          end
        end
        StFind: begin
          if (kind_q == KindDown ? !act_q[idx] : slot_hit) begin
            unique case (kind_q)
              KindDown: begin
                act_q[idx] <= 1'b1;
                fid_q[idx] <= id_q;
                org_q[idx] <= {y_q, x_q};
                pos_q[idx] <= {y_q, x_q};
                own_q[idx] <= (x_q < zone_q) && !held_q;
              end
              KindMotion: pos_q[idx] <= {y_q, x_q};
              default: begin
                act_q[idx] <= 1'b0;
                own_q[idx] <= 1'b0;
              end
            endcase
            state_q <= StScan;
          end else if (idx_q == LastSlot) begin
            state_q <= (kind_q == KindUp) ? StScan : StIdle;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
          if (state_d == StScan) begin
            idx_q <= '0;
            circ_q <= 3'd5;
            sq_ph_q <= 1'b0;
            mask_q <= '0;
            stick_q <= 1'b0;
          end
        end
        StScan: begin
          // circ_q 5..7 square the button radius, start radius and travel first;
          // then per button finger slot: for each circle square dx then dy, then compare to r*r
          if (circ_q >= 3'd5) begin
            unique case (circ_q)
              3'd5:    r2b_q <= sq_p[31:0];
              3'd6:    r2s_q <= sq_p[31:0];
              default: t2_q <= sq_p[31:0];
            endcase
            circ_q <= (circ_q == 3'd7) ? 3'd0 : circ_q + 3'd1;
          end else if (!act_q[idx] || own_q[idx]) begin
            if (act_q[idx]) begin
              stick_q <= 1'b1;
              sorg_q <= org_q[idx];
              scur_q <= pos_q[idx];
            end
            circ_q <= '0;
            sq_ph_q <= 1'b0;
            if (idx_q == LastSlot) state_q <= StRoot;
            else idx_q <= idx_q + 1'b1;
          end else if (!sq_ph_q) begin
            acc_q <= {2'b0, sq_p};
            sq_ph_q <= 1'b1;
          end else begin
            if (acc_q + {2'b0, sq_p} <= {4'b0, r2})
              mask_q[circ_q] <= 1'b1;
            sq_ph_q <= 1'b0;
            if (circ_q == 3'(NumCircles - 1)) begin
              circ_q <= '0;
              if (idx_q == LastSlot) state_q <= StRoot;
              else idx_q <= idx_q + 1'b1;
            end else begin
              circ_q <= circ_q + 3'd1;
            end
          end
          if (circ_q < 3'd5 && (idx_q == LastSlot) &&
              (!act_q[idx] || own_q[idx] || (sq_ph_q && circ_q == 3'(NumCircles - 1)))) begin
            acc_q <= '0;
            rbit_q <= '0;
            circ_q <= '0;
          end
        end
        StRoot: begin
          // circ_q 0: dx^2, 1: dy^2 and setup, 2: bit-by-bit root
          if (!stick_q) begin
            state_q <= StOut;
          end else if (circ_q == 3'd0) begin
            acc_q <= {2'b0, sq_p};
            sq_ph_q <= 1'b1;
            circ_q <= 3'd1;
          end else if (circ_q == 3'd1) begin
            rv_q <= 34'(acc_q + {2'b0, sq_p});
            rres_q <= '0;
            rbit_q <= 34'd1 << 32;
            circ_q <= 3'd2;
          end else if (rbit_q != '0) begin
            if ({2'b0, rv_q} >= rtrial) begin
              rv_q <= rv_q - 34'(rtrial);
              rres_q <= (rres_q >> 1) + rbit_q;
            end else begin
              rres_q <= rres_q >> 1;
            end
            rbit_q <= rbit_q >> 2;
          end else begin
            // d2 = rv original lost; compare via result: d2 > T^2 iff root path
            state_q <= StDivX;
            divgo_q <= 1'b1;
          end
          if (circ_q == 3'd1) begin
            if (34'(acc_q + {2'b0, sq_p}) <= {2'b0, t2_q})
              div_q <= {2'b0, travel_q};
            else
              div_q <= 18'h3ffff;
          end
          if (circ_q == 3'd2 && rbit_q == '0 && div_q == 18'h3ffff)
            div_q <= {1'b0, rres_q[16:0]};
        end
        StDivX: state_q <= StWaitX;
        StWaitX: if (!dbusy) begin
          ax_q <= (div_q == '0) ? 16'd0 : axis_q_w;
          divgo_q <= 1'b1;
          state_q <= StDivY;
        end
        StDivY: state_q <= StWaitY;
        StWaitY: if (!dbusy) state_q <= StOut;
        StOut: if (!ov_q || m_axis_tready) begin
          ov_q <= 1'b1;
          held_q <= stick_q;
          od_q <= stick_q ?
            {2'b0, scur_q[31:16], scur_q[15:0], sorg_q[31:16], sorg_q[15:0],
             ((div_q == '0) ? 16'd0 : axis_q_w), ax_q, 1'b1, mask_q} :
            {2'b0, 96'd0, 1'b0, mask_q};
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
endmodule

// ===== design/tgm_checker.sv =====
`timescale 1ns / 1ps
module tgm_checker
  import tgm_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  // kind 3 items are dropped on the spot, so only real events make the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != KindNone |=> !s_axis_tready)
    else $error("accepted item while busy");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[5] |-> m_axis_tdata[101:6] == '0)
    else $error("stick fields nonzero without stick");
endmodule

bind touch_to_gamepad_mapper_top tgm_checker u_chk (.*);
